// ----- hdl/sorted_list_engine_defines.svh -----
// Assertion macros shared by the sorted list engine RTL.
`ifndef SORTED_LIST_ENGINE_DEFINES_SVH
`define SORTED_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTH
// Implication property checked on every rising clock edge outside reset.
`define SLE_ASSERT(lbl, clk_i, rst_n_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) prop) else $error(msg);
// Condition that must never be true outside reset.
`define SLE_NEVER(lbl, clk_i, rst_n_i, cond, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) !(cond)) else $error(msg);
`else
`define SLE_ASSERT(lbl, clk_i, rst_n_i, prop, msg)
`define SLE_NEVER(lbl, clk_i, rst_n_i, cond, msg)
`endif

`endif

// ----- hdl/slist_pkg.sv -----
// Shared types and constants of the sorted list engine.
package slist_pkg;

	localparam int CAPACITY   = 16;
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int OUT_CNT_W  = 5;
	localparam int VAL_W      = 32;

	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [OUT_CNT_W-1:0] out_cnt_t;

	typedef enum logic [1:0] {
		CMD_INSERT,
		CMD_DELETE,
		CMD_SEARCH,
		CMD_DUMP
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_REMOVED  = 3'd1,
		ST_FOUND    = 3'd2,
		ST_MISSING  = 3'd3,
		ST_EMPTY    = 3'd4,
		ST_FULL     = 3'd5,
		ST_DUMP     = 3'd6
	} status_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_DUMP
	} fsm_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_DELETE,
		CELL_ROTATE
	} cell_op_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		cell_op_t                op;
		logic signed [VAL_W-1:0] value;
	} cell_ctl_t;

endpackage

// ----- hdl/sorted_list_engine.sv -----
// Sorted list engine: keeps up to CAPACITY signed 32-bit values in ascending
// order in a row of cells that compare against the operand in parallel.
// Insert, delete and search each give one result: the transaction is accepted
// when in_stall is low and its single result is loaded into the output
// register at that same edge, so it is presented from the next cycle on.
// A dump of N entries gives N results, one per cycle while out_stall is low, by
// rotating the cell row one slot per result; the first is loaded from the dump
// state entered on acceptance, and the input stalls until the last is loaded.
// An empty dump gives a single EMPTY result. One item is in work at a time; a
// new one is taken in the same cycle the previous result is handed downstream.
`include "sorted_list_engine_defines.svh"

module sorted_list_engine (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         cmd,
	input  logic signed [slist_pkg::VAL_W-1:0] value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [2:0]                         status,
	output logic signed [slist_pkg::VAL_W-1:0] entry_value,
	output logic                               last,
	output logic [slist_pkg::OUT_CNT_W-1:0]    entry_count
);

	localparam int CAP = slist_pkg::CAPACITY;

	slist_pkg::fsm_t      state_q, state_d;
	slist_pkg::cnt_t      count_q, count_d;
	slist_pkg::idx_t      dump_idx_q, dump_idx_d;
	slist_pkg::cell_ctl_t ctl;

	logic                               out_valid_q;
	slist_pkg::status_t                 status_q, res_status;
	logic signed [slist_pkg::VAL_W-1:0] entry_value_q, res_value;
	logic                               last_q, res_last;
	slist_pkg::out_cnt_t                entry_count_q;
	logic                               load;

	logic signed [slist_pkg::VAL_W-1:0] cell_val [CAP];
	logic                               cell_lt  [CAP];
	logic                               cell_hit [CAP];

	logic out_free, in_acc, empty, full, found, dump_last;

	// Handshake
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != slist_pkg::FSM_IDLE) || !out_free;
	assign in_acc    = in_valid && !in_stall;

	assign empty     = (count_q == '0);
	assign full      = (count_q >= slist_pkg::cnt_t'(CAP));
	assign found     = cell_hit[CAP-1];
	assign dump_last = (slist_pkg::cnt_t'(dump_idx_q) + 1'b1) == count_q;

	// Cell row
	for (genvar i = 0; i < CAP; i++) begin : g_cell
		slist_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.occ      (slist_pkg::cnt_t'(i) < count_q),
			.is_tail  (count_q == slist_pkg::cnt_t'(i + 1)),
			.lt_prev  ((i == 0) ? 1'b1 : cell_lt[(i == 0) ? 0 : i - 1]),
			.hit_prev ((i == 0) ? 1'b0 : cell_hit[(i == 0) ? 0 : i - 1]),
			.val_prev (cell_val[(i == 0) ? 0 : i - 1]),
			.val_next (cell_val[(i == CAP - 1) ? i : i + 1]),
			.val_head (cell_val[0]),
			.val      (cell_val[i]),
			.lt       (cell_lt[i]),
			.hit      (cell_hit[i])
		);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			slist_pkg::FSM_IDLE: begin
				if (in_acc && (slist_pkg::cmd_t'(cmd) == slist_pkg::CMD_DUMP) && !empty)
					state_d = slist_pkg::FSM_DUMP;
			end
			slist_pkg::FSM_DUMP: begin
				if (out_free && dump_last)
					state_d = slist_pkg::FSM_IDLE;
			end
			default: state_d = slist_pkg::FSM_IDLE;
		endcase
	end

	// Cell control, result and count
	always_comb begin
		ctl.op     = slist_pkg::CELL_HOLD;
		ctl.value  = value;
		load       = 1'b0;
		res_status = slist_pkg::ST_MISSING;
		res_value  = value;
		res_last   = 1'b1;
		count_d    = count_q;
		dump_idx_d = dump_idx_q;
		unique case (state_q)
			slist_pkg::FSM_IDLE: begin
				dump_idx_d = '0;
				if (in_acc) begin
					unique case (slist_pkg::cmd_t'(cmd))
						slist_pkg::CMD_INSERT: begin
							load = 1'b1;
							if (full) begin
								res_status = slist_pkg::ST_FULL;
							end else begin
								ctl.op     = slist_pkg::CELL_INSERT;
								res_status = slist_pkg::ST_INSERTED;
								count_d    = count_q + 1'b1;
							end
						end
						slist_pkg::CMD_DELETE, slist_pkg::CMD_SEARCH: begin
							load = 1'b1;
							if (empty)
								res_status = slist_pkg::ST_EMPTY;
							else if (!found)
								res_status = slist_pkg::ST_MISSING;
							else if (slist_pkg::cmd_t'(cmd) == slist_pkg::CMD_SEARCH)
								res_status = slist_pkg::ST_FOUND;
							else begin
								ctl.op     = slist_pkg::CELL_DELETE;
								res_status = slist_pkg::ST_REMOVED;
								count_d    = count_q - 1'b1;
							end
						end
						slist_pkg::CMD_DUMP: begin
							// non-empty dump is emitted from the dump state
							if (empty) begin
								load       = 1'b1;
								res_status = slist_pkg::ST_EMPTY;
								res_value  = '0;
							end
						end
						default: load = 1'b0;
					endcase
				end
			end
			slist_pkg::FSM_DUMP: begin
				res_status = slist_pkg::ST_DUMP;
				res_value  = cell_val[0];
				res_last   = dump_last;
				if (out_free) begin
					load       = 1'b1;
					ctl.op     = slist_pkg::CELL_ROTATE;
					dump_idx_d = dump_idx_q + 1'b1;
				end
			end
			default: load = 1'b0;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= slist_pkg::FSM_IDLE;
			count_q     <= '0;
			dump_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			dump_idx_q  <= dump_idx_d;
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (load) begin
			status_q      <= res_status;
			entry_value_q <= res_value;
			last_q        <= res_last;
			entry_count_q <= slist_pkg::out_cnt_t'(count_d);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_value = entry_value_q;
	assign last        = last_q;
	assign entry_count = entry_count_q;

	`SLE_NEVER(a_count_bound, clk, arst_n, count_q > slist_pkg::cnt_t'(CAP), "count above capacity")
	`SLE_ASSERT(a_dump_blocks_input, clk, arst_n, (state_q == slist_pkg::FSM_DUMP) |-> in_stall, "input taken during dump")
	`SLE_ASSERT(a_dump_idx_range, clk, arst_n, (state_q == slist_pkg::FSM_DUMP) |-> (slist_pkg::cnt_t'(dump_idx_q) < count_q), "dump index past count")
	`SLE_ASSERT(a_insert_count, clk, arst_n, (in_acc && (cmd == slist_pkg::CMD_INSERT) && !full) |=> (count_q == $past(count_q) + 1'b1), "insert did not grow list")
	`SLE_ASSERT(a_dump_count_stable, clk, arst_n, (state_q == slist_pkg::FSM_DUMP) |=> $stable(count_q), "count moved during dump")

endmodule

// ----- hdl/slist_cell.sv -----
// One slot of the sorted list: holds a value and trades it with its neighbors.
module slist_cell (
	input  logic                               clk,
	input  slist_pkg::cell_ctl_t               ctl,
	input  logic                               occ,
	input  logic                               is_tail,
	input  logic                               lt_prev,
	input  logic                               hit_prev,
	input  logic signed [slist_pkg::VAL_W-1:0] val_prev,
	input  logic signed [slist_pkg::VAL_W-1:0] val_next,
	input  logic signed [slist_pkg::VAL_W-1:0] val_head,
	output logic signed [slist_pkg::VAL_W-1:0] val,
	output logic                               lt,
	output logic                               hit
);

	logic signed [slist_pkg::VAL_W-1:0] val_q;
	logic signed [slist_pkg::VAL_W-1:0] val_d;

	// Local compares; stored values are ascending so lt forms a prefix
	assign lt  = occ && ($signed(val_q) < $signed(ctl.value));
	assign hit = hit_prev || (occ && (val_q == ctl.value));
	assign val = val_q;

	// Next value: keep, take the new item, or take a neighbor's or the head's value
	always_comb begin
		val_d = val_q;
		unique case (ctl.op)
			slist_pkg::CELL_HOLD: begin
				val_d = val_q;
			end
			slist_pkg::CELL_INSERT: begin
				if (lt)
					val_d = val_q;
				else if (lt_prev)
					val_d = ctl.value;
				else
					val_d = val_prev;
			end
			slist_pkg::CELL_DELETE: begin
				val_d = hit ? val_next : val_q;
			end
			slist_pkg::CELL_ROTATE: begin
				val_d = is_tail ? val_head : val_next;
			end
			default: val_d = val_q;
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

endmodule
